@@ rtl/core/sle_pkg.sv @@
// sle_pkg: shared types and codes for the sorted list engine.
// Command and status codes, cell operation and control struct, FSM states.
// No dependencies.
`default_nettype none

package sle_pkg;

    // Command codes carried on the input tuser
    localparam logic [2:0] FN_INSERT    = 3'd0;
    localparam logic [2:0] FN_DELETE    = 3'd1;
    localparam logic [2:0] FN_LIST_ASC  = 3'd2;
    localparam logic [2:0] FN_LIST_DESC = 3'd3;
    localparam logic [2:0] FN_LENGTH    = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Width of the count field on the result
    localparam int unsigned ECNT_W = 5;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     found;
    } t_cell_ctl;

    typedef enum logic {
        FSM_IDLE,
        FSM_LIST
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/sle_cell.sv @@
// sle_cell: one slot of the sorted row, holding a single entry.
// Compares against the command value and shifts left or right with its neighbours.
// Depends on sle_pkg.
`default_nettype none

module sle_cell (
    input  wire logic                signed [31:0] i_value,
    input  wire logic                              i_clk,
    input  wire sle_pkg::t_cell_ctl                i_ctl,
    input  wire logic                              i_valid,
    input  wire logic                              i_at_count,
    input  wire logic                              i_left_ge,
    input  wire logic                signed [31:0] i_left_entry,
    input  wire logic                signed [31:0] i_right_entry,
    output logic                     signed [31:0] o_entry,
    output logic                                   o_ge,
    output logic                                   o_eq
);
    import sle_pkg::*;

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;

    // Flags: entry not smaller (seen by the next cell) / equal (fed to the match reduction)
    assign o_ge    = i_valid && (r_entry >= i_value);
    assign o_eq    = i_valid && (r_entry == i_value);
    assign o_entry = r_entry;

    // Insert: take left entry once past the slot, value at the slot.
    // Delete: everything from the first match onwards pulls from the right.
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_left_ge) begin
                    n_entry = i_left_entry;
                end else if (o_ge || i_at_count) begin
                    n_entry = i_value;
                end
            end
            CELL_DELETE: begin
                if (i_ctl.found && o_ge) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ rtl/core/sle_chain.sv @@
// sle_chain: row of sle_cell slots with neighbour wiring, match reduction
// and the read select used during enumeration. Depends on sle_pkg, sle_cell.
`default_nettype none

module sle_chain #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                       i_clk,
    input  wire sle_pkg::t_cell_op          i_op,
    input  wire logic        signed [31:0]  i_value,
    input  wire logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_rd_idx,
    output logic                            o_found,
    output logic             signed [31:0]  o_rd_entry
);
    import sle_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic signed [31:0] w_entry [CAPACITY];
    logic               w_ge    [CAPACITY];
    logic [CAPACITY-1:0] w_eq;
    t_cell_ctl          w_ctl;

    // Any valid slot equal to the value
    assign o_found   = |w_eq;
    assign w_ctl.op    = i_op;
    assign w_ctl.found = o_found;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic               w_left_ge;
            logic signed [31:0] w_left;
            logic signed [31:0] w_right;
            logic               w_eq_bit;

            if (g == 0) begin : g_first
                assign w_left_ge = 1'b0;
                assign w_left    = w_entry[g];
            end else begin : g_mid
                assign w_left_ge = w_ge[g-1];
                assign w_left    = w_entry[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_entry[g];
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            assign w_eq[g] = w_eq_bit;

            sle_cell u_cell (
                .i_value       (i_value),
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_valid       (CW'(g) < i_count),
                .i_at_count    (CW'(g) == i_count),
                .i_left_ge     (w_left_ge),
                .i_left_entry  (w_left),
                .i_right_entry (w_right),
                .o_entry       (w_entry[g]),
                .o_ge          (w_ge[g]),
                .o_eq          (w_eq_bit)
            );
        end
    endgenerate

    // Enumeration read select
    assign o_rd_entry = w_entry[i_rd_idx];

endmodule

`default_nettype wire

@@ rtl/core/sorted_list_engine_top.sv @@
// sorted_list_engine_top: command decode, enumeration sequencer and output
// register around the sorted cell row. Depends on sle_pkg, sle_chain.
//
//  Channel | Dir | Fields (low bit up)
//  s_axis  | in  | tdata: value[31:0]; tuser: func[2:0]
//  m_axis  | out | tdata: item[31:0], entry_count[36:32], zero[39:37];
//          |     | tuser: status[1:0]; tlast: last
//
// Insert, delete and length complete on acceptance: every cell compares and
// shifts in parallel in the same clock. Enumeration emits one entry per cycle
// after the accepting cycle, unless the output stalls, and input is held off
// meanwhile; an empty list gives a single EMPTY result. Results sit in one output
// register; input is taken while that register is empty or being drained. Reset
// (synchronous, active low) clears the count and control; cell contents are
// not cleared.
`default_nettype none

module sorted_list_engine_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value[31:0]
    input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // item[31:0], entry_count[36:32], zero
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    output logic             m_axis_tlast
);
    import sle_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_desc, n_desc;
    logic                r_m_valid;
    logic signed [31:0]  r_item, n_item;
    logic [1:0]          r_status, n_status;
    logic                r_last, n_last;
    logic [ECNT_W-1:0]   r_ecnt;

    logic                out_free;
    logic                in_acc;
    logic                load;
    logic                is_full;
    logic                is_empty;
    logic                is_list;
    logic                list_last;
    logic [CW-1:0]       desc_pos;
    logic [IW-1:0]       rd_idx;
    logic [CW+ECNT_W-1:0] cnt_ext;
    t_cell_op            cell_op;
    logic                found;
    logic signed [31:0]  rd_entry;

    // Handshake
    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == FSM_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign is_full   = (r_count == CW'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign is_list   = (s_axis_tuser == FN_LIST_ASC) || (s_axis_tuser == FN_LIST_DESC);
    assign list_last = ((CW'(r_idx) + CW'(1)) == r_count);

    // Enumeration position
    assign desc_pos = r_count - CW'(1) - CW'(r_idx);
    assign rd_idx   = r_desc ? desc_pos[IW-1:0] : r_idx;

    sle_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk      (i_clk),
        .i_op       (cell_op),
        .i_value    (s_axis_tdata),
        .i_count    (r_count),
        .i_rd_idx   (rd_idx),
        .o_found    (found),
        .o_rd_entry (rd_entry)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: begin
                if (in_acc && is_list && !is_empty) begin
                    n_state = FSM_LIST;
                end
            end
            FSM_LIST: begin
                if (out_free && list_last) begin
                    n_state = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    // Command decode and result build
    always_comb begin
        cell_op  = CELL_HOLD;
        load     = 1'b0;
        n_count  = r_count;
        n_idx    = r_idx;
        n_desc   = r_desc;
        n_item   = '0;
        n_status = ST_OK;
        n_last   = 1'b1;
        case (r_state)
            FSM_IDLE: begin
                if (in_acc) begin
                    case (s_axis_tuser)
                        FN_INSERT: begin
                            load = 1'b1;
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                cell_op = CELL_INSERT;
                                n_count = r_count + CW'(1);
                            end
                        end
                        FN_DELETE: begin
                            load = 1'b1;
                            if (found) begin
                                cell_op = CELL_DELETE;
                                n_count = r_count - CW'(1);
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        FN_LIST_ASC, FN_LIST_DESC: begin
                            n_idx  = '0;
                            n_desc = (s_axis_tuser == FN_LIST_DESC);
                            if (is_empty) begin
                                load     = 1'b1;
                                n_status = ST_EMPTY;
                            end
                        end
                        FN_LENGTH: begin
                            load = 1'b1;
                        end
                        default: begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            FSM_LIST: begin
                if (out_free) begin
                    load   = 1'b1;
                    n_item = rd_entry;
                    n_last = list_last;
                    n_idx  = r_idx + IW'(1);
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign cnt_ext = {{ECNT_W{1'b0}}, n_count};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FSM_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_desc    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_desc  <= n_desc;
            if (load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item   <= n_item;
            r_status <= n_status;
            r_last   <= n_last;
            r_ecnt   <= cnt_ext[ECNT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_ecnt, r_item};
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_list_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FSM_LIST) |-> ((r_count != '0) && (CW'(r_idx) < r_count)))
        else $error("enumeration index outside stored entries");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (s_axis_tuser == FN_INSERT) && is_full) |=> (r_count == $past(r_count)))
        else $error("refused insert changed the count");

endmodule

`default_nettype wire
